### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/b64kd_pkg.sv
// ----------------------------------------------------------------------------
// b64kd_pkg
// Shared types and constants of the base64 key decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64kd_pkg;

  localparam int KEY_LENGTH_W = 12;
  // One bit wider than the key length, so byte counts plus a group never wrap.
  localparam int LEN_W = KEY_LENGTH_W + 1;
  localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RST = 12'd32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LONG    = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // Results caused by one input word: up to three bytes, then an optional status.
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] data;
    logic            has_status;
    logic [1:0]      status;
  } grp_t;

endpackage

`default_nettype wire

### sv/b64kd_front.sv
// ----------------------------------------------------------------------------
// b64kd_front
// Classify characters, pack digits into groups and decide the results.
// ----------------------------------------------------------------------------
`default_nettype none

module b64kd_front #(
  parameter int MAX_KEY_BYTES = 2048
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [b64kd_pkg::KEY_LENGTH_W-1:0]   cfg_wdata_i,
  input  wire logic                                 accept_i,
  input  wire b64kd_pkg::in_word_t                  in_word_i,
  output logic                                      push_o,
  output b64kd_pkg::grp_t                           grp_o
);

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_PAD   = 2'd1,
    CLS_SPACE = 2'd2,
    CLS_BAD   = 2'd3
  } class_e;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] LOWER_BASE   = 8'd26;
  localparam logic [7:0] DECIMAL_BASE = 8'd52;
  localparam logic [5:0] DIGIT_PLUS   = 6'd62;
  localparam logic [5:0] DIGIT_SLASH  = 6'd63;

  localparam int LW = b64kd_pkg::LEN_W;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_KEY_BYTES);

  logic [b64kd_pkg::KEY_LENGTH_W-1:0] klen_q;
  logic [23:0]                        group_q, group_d;
  logic [1:0]                         dc_q, dc_d;
  logic [b64kd_pkg::KEY_LENGTH_W-1:0] bytes_q, bytes_d;
  logic                               drain_q, drain_d;

  class_e          cls;
  logic [5:0]      digit;
  logic [LW-1:0]   len;
  logic [LW-1:0]   bytes_ext;
  logic [23:0]     new_group;
  logic            over3;
  logic [1:0]      fin_need;
  logic [LW-1:0]   fin_total;
  logic            fin_over;
  b64kd_pkg::grp_t fin_grp;

  // Character class and digit value.
  always_comb begin
    cls   = CLS_BAD;
    digit = '0;
    case (in_word_i.char_code) inside
      [CHAR_UPPER_A:CHAR_UPPER_Z]: begin
        cls   = CLS_DIGIT;
        digit = 6'(in_word_i.char_code - CHAR_UPPER_A);
      end
      [CHAR_LOWER_A:CHAR_LOWER_Z]: begin
        cls   = CLS_DIGIT;
        digit = 6'(in_word_i.char_code - CHAR_LOWER_A + LOWER_BASE);
      end
      [CHAR_ZERO:CHAR_NINE]: begin
        cls   = CLS_DIGIT;
        digit = 6'(in_word_i.char_code - CHAR_ZERO + DECIMAL_BASE);
      end
      CHAR_PLUS: begin
        cls   = CLS_DIGIT;
        digit = DIGIT_PLUS;
      end
      CHAR_SLASH: begin
        cls   = CLS_DIGIT;
        digit = DIGIT_SLASH;
      end
      CHAR_PAD:                             cls = CLS_PAD;
      CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF: cls = CLS_SPACE;
      default:                              cls = CLS_BAD;
    endcase
  end

  assign len       = ({1'b0, klen_q} > MaxLen) ? MaxLen : {1'b0, klen_q};
  assign bytes_ext = {1'b0, bytes_q};
  assign new_group = {group_q[17:0], digit};
  assign over3     = (bytes_ext + LW'(3)) > len;

  // Flush of a partial group followed by the final status.
  always_comb begin
    case (dc_q)
      2'd3:    fin_need = 2'd2;
      2'd2:    fin_need = 2'd1;
      default: fin_need = 2'd0;
    endcase
    fin_total = bytes_ext + LW'(fin_need);
    fin_over  = (fin_need != 2'd0) && (fin_total > len);
    fin_grp            = '0;
    fin_grp.has_status = 1'b1;
    if (fin_over) begin
      fin_grp.status = b64kd_pkg::ST_LONG;
    end else begin
      fin_grp.nbytes = fin_need;
      if (dc_q == 2'd3) begin
        fin_grp.data[0] = group_q[17:10];
        fin_grp.data[1] = group_q[9:2];
      end else begin
        fin_grp.data[0] = group_q[11:4];
      end
      if (fin_total < len) begin
        fin_grp.status = b64kd_pkg::ST_SHORT;
      end else if (fin_total > len) begin
        fin_grp.status = b64kd_pkg::ST_LONG;
      end else begin
        fin_grp.status = b64kd_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    group_d = group_q;
    dc_d    = dc_q;
    bytes_d = bytes_q;
    drain_d = drain_q;
    push_o  = 1'b0;
    grp_o   = '0;
    if (accept_i) begin
      if (in_word_i.end_of_input) begin
        if (!drain_q) begin
          push_o = 1'b1;
          grp_o  = fin_grp;
        end
        group_d = '0;
        dc_d    = '0;
        bytes_d = '0;
        drain_d = 1'b0;
      end else if (!drain_q) begin
        case (cls)
          CLS_DIGIT: begin
            group_d = new_group;
            if (dc_q != 2'd3) begin
              dc_d = dc_q + 2'd1;
            end else begin
              dc_d   = '0;
              push_o = 1'b1;
              if (over3) begin
                drain_d          = 1'b1;
                grp_o.has_status = 1'b1;
                grp_o.status     = b64kd_pkg::ST_LONG;
              end else begin
                grp_o.nbytes  = 2'd3;
                grp_o.data[0] = new_group[23:16];
                grp_o.data[1] = new_group[15:8];
                grp_o.data[2] = new_group[7:0];
                bytes_d       = bytes_q + 12'd3;
                group_d       = '0;
              end
            end
          end
          CLS_PAD: begin
            push_o  = 1'b1;
            grp_o   = fin_grp;
            drain_d = 1'b1;
            if (!fin_over) begin
              dc_d    = '0;
              group_d = '0;
              bytes_d = fin_total[b64kd_pkg::KEY_LENGTH_W-1:0];
            end
          end
          CLS_SPACE: begin
          end
          default: begin
            push_o           = 1'b1;
            drain_d          = 1'b1;
            grp_o.has_status = 1'b1;
            grp_o.status     = b64kd_pkg::ST_INVALID;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q  <= b64kd_pkg::KEY_LENGTH_RST;
      group_q <= '0;
      dc_q    <= '0;
      bytes_q <= '0;
      drain_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        klen_q <= cfg_wdata_i;
      end
      group_q <= group_d;
      dc_q    <= dc_d;
      bytes_q <= bytes_d;
      drain_q <= drain_d;
    end
  end

endmodule

`default_nettype wire

### sv/b64kd_queue.sv
// ----------------------------------------------------------------------------
// b64kd_queue
// Short FIFO of result groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64kd_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire b64kd_pkg::grp_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output b64kd_pkg::grp_t      data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  b64kd_pkg::grp_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/b64kd_back.sv
// ----------------------------------------------------------------------------
// b64kd_back
// Unroll result groups into output words, one per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64kd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              grp_valid_i,
  input  wire b64kd_pkg::grp_t   grp_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output b64kd_pkg::out_word_t   out_word_o
);

  logic [1:0]           idx_q;
  logic                 valid_q;
  b64kd_pkg::out_word_t word_q;
  b64kd_pkg::out_word_t piece;
  logic                 last_piece;
  logic                 load;

  // Bytes come first in order, the status word closes the group.
  always_comb begin
    piece = '0;
    if (idx_q < grp_i.nbytes) begin
      piece.kind      = b64kd_pkg::KIND_DATA;
      piece.data_byte = grp_i.data[idx_q];
    end else begin
      piece.kind   = b64kd_pkg::KIND_STATUS;
      piece.status = grp_i.status;
      piece.last   = 1'b1;
    end
    last_piece = grp_i.has_status ? (idx_q == grp_i.nbytes)
                                  : (2'(idx_q + 2'd1) == grp_i.nbytes);
  end

  assign load        = grp_valid_i && (!valid_q || out_ready_i);
  assign pop_o       = load && last_piece;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= piece;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last_piece ? '0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### sv/base64_key_decoder.sv
// ----------------------------------------------------------------------------
// base64_key_decoder
// Decode base64 text, one character per word, into key bytes and a status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) takes one character
//   per word; set end_of_input to close a key. Output channel (out_valid_o /
//   out_ready_i / out_word_o) gives data bytes (kind 0) and one final status
//   word per key (kind 1, last 1).
//   cfg_we_i writes cfg_wdata_i into the key_length register; write it only
//   while no word is in flight. The length saturates at MAX_KEY_BYTES.
// Path and rate:
//   Results of an accepted character pass the queue, then the output
//   register. Input runs at one character per cycle while in_ready_o is high;
//   the output register drains one result word per cycle while out_ready_i
//   is high, so a full group of four digits (three bytes) keeps pace with the input.
// Reset:
//   Clears the decoder state and sets key_length to 32; no output is valid.
// Back-pressure:
//   A stall on the output holds the output register; the queue of
//   QUEUE_DEPTH result groups keeps taking input until it fills, then
//   in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_key_decoder #(
  parameter int MAX_KEY_BYTES = 2048,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [b64kd_pkg::KEY_LENGTH_W-1:0] cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire b64kd_pkg::in_word_t                in_word_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output b64kd_pkg::out_word_t                    out_word_o
);

  logic            accept;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  b64kd_pkg::grp_t push_grp;
  b64kd_pkg::grp_t head_grp;

  // Take a character whenever the queue has room for its results.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // Front: classify the character and decide its whole group of results.
  b64kd_front #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .grp_o      (push_grp)
  );

  // Queue: decouple the front, one word per cycle while the queue has room, from the back.
  b64kd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_grp),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .data_o (head_grp)
  );

  // Back: hand out the group's words through the output register.
  b64kd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_valid_i(q_valid),
    .grp_i      (head_grp),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

### sv/b64kd_checker.sv
// ----------------------------------------------------------------------------
// b64kd_checker
// Port-level checks of the base64 key decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module b64kd_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire b64kd_pkg::out_word_t out_word_i
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output word dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_word_i), "output word changed while stalled")
  `ASSERT_SAME(a_status_form, clk_i, rst_ni, out_valid_i && (out_word_i.kind == b64kd_pkg::KIND_STATUS), out_word_i.last && (out_word_i.data_byte == 8'd0), "status word malformed")
  `ASSERT_SAME(a_data_form, clk_i, rst_ni, out_valid_i && (out_word_i.kind == b64kd_pkg::KIND_DATA), !out_word_i.last && (out_word_i.status == b64kd_pkg::ST_OK), "data word malformed")

endmodule

bind base64_key_decoder b64kd_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_i (out_word_o)
);

`default_nettype wire
